>>> sv/thruster_command_shaper_assert.svh
// Assertion macros shared by the checker of the thruster command shaper.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef THRUSTER_COMMAND_SHAPER_ASSERT_SVH
`define THRUSTER_COMMAND_SHAPER_ASSERT_SVH

// Clocked check, off while reset is asserted
`define TCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked check that also runs during reset
`define TCS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> sv/tcs_pkg.sv
// Package of the thruster command shaper: widths, register indexes and
// the request/response structs of the serial divider. No dependencies.
`timescale 1ns / 1ps

package tcs_pkg;

  localparam int NUM_W = 37;   // dividend width (17 bit magnitude << 20)
  localparam int DEN_W = 34;   // divisor width (64*b + a*|x|)
  localparam int MAG_W = 17;   // working thrust value, signed
  localparam int ACT_W = 14;   // stored active thrust, signed
  localparam int PULSE_W = 12;
  localparam int NUM_THR = 8;

  localparam logic [1:0] CFG_COEF_A  = 2'd0;
  localparam logic [1:0] CFG_COEF_B  = 2'd1;
  localparam logic [1:0] CFG_NEUTRAL = 2'd2;
  localparam logic [1:0] CFG_LED_REV = 2'd3;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
    logic [DEN_W-1:0] rem;
  } div_rsp_t;

endpackage

>>> sv/thruster_command_shaper.sv
// Thruster command shaper: demand correction, group scaling, slew,
// PWM widths, LED mask and ESC stall reset.
// Depends on tcs_pkg and tcs_serial_div.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) transfers eight demands, the
//   throttle cut and the supply power. Output channel (out_valid_o /
//   out_ready_i) transfers eight pulse widths, the LED mask and stall_reset.
//   The config channel (cfg_valid_i / cfg_ready_o) is always ready and
//   writes register cfg_index_i with cfg_data_i; write it only while idle.
//   One item is processed at a time. All divisions run on one shared
//   bit-serial divider with 37 steps. A new item is accepted only
//   once the previous one has left the sequencer: in_ready_o is high
//   only in the idle state.
//   A finished result sits in the output register; the next item is
//   accepted meanwhile, and it only waits at its end if the receiver
//   still stalls the previous result.
//   Reset clears the active thrusts, the stall counter and the output
//   valid, and loads the register defaults.
`timescale 1ns / 1ps

module thruster_command_shaper #(
  parameter int STALL_LIMIT = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [15:0] demand_hhf_i,
  input  logic signed [15:0] demand_hhb_i,
  input  logic signed [15:0] demand_hvb_i,
  input  logic signed [15:0] demand_hvf_i,
  input  logic signed [15:0] demand_vhf_i,
  input  logic signed [15:0] demand_vhb_i,
  input  logic signed [15:0] demand_vvb_i,
  input  logic signed [15:0] demand_vvf_i,
  input  logic [6:0]  throttle_cut_i,
  input  logic [15:0] supply_power_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] pulse_hhf_o,
  output logic [11:0] pulse_hhb_o,
  output logic [11:0] pulse_hvb_o,
  output logic [11:0] pulse_hvf_o,
  output logic [11:0] pulse_vhf_o,
  output logic [11:0] pulse_vhb_o,
  output logic [11:0] pulse_vvb_o,
  output logic [11:0] pulse_vvf_o,
  output logic [7:0]  led_mask_o,
  output logic        stall_reset_o
);
  import tcs_pkg::*;

  localparam logic [4:0] STALL_LIM = 5'(STALL_LIMIT);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CORR  = 4'd1;
  localparam logic [3:0] S_CMUL  = 4'd2;
  localparam logic [3:0] S_CDIV  = 4'd3;
  localparam logic [3:0] S_PEAK  = 4'd4;
  localparam logic [3:0] S_SCALE = 4'd5;
  localparam logic [3:0] S_SMUL  = 4'd6;
  localparam logic [3:0] S_SDIV  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_OMUL  = 4'd9;
  localparam logic [3:0] S_ODIV  = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  // gain in fifths from throttle and power
  function automatic logic [4:0] gain5(input logic [6:0] thr, input logic hi_pwr);
    logic [4:0] g;
    logic [4:0] r;
    case (thr) inside
      7'd0:           g = 5'd20;
      [7'd1:7'd25]:   g = 5'd15;
      [7'd26:7'd50]:  g = 5'd10;
      [7'd51:7'd75]:  g = 5'd5;
      default:        g = 5'd0;
    endcase
    case (g)
      5'd20:   r = 5'd16;
      5'd15:   r = 5'd12;
      5'd10:   r = 5'd8;
      5'd5:    r = 5'd4;
      default: r = 5'd0;
    endcase
    return hi_pwr ? r : g;
  endfunction

  // registers
  logic [15:0]        coef_a_q, coef_b_q;
  logic [11:0]        neutral_q;
  logic               led_rev_q;
  logic [3:0]         state_q, state_d;
  logic [2:0]         k_q, k_d;
  logic [MAG_W-1:0]   t_q [NUM_THR];
  logic [MAG_W-1:0]   t_d [NUM_THR];
  logic [ACT_W-1:0]   act_q [NUM_THR];
  logic [ACT_W-1:0]   act_d [NUM_THR];
  logic [4:0]         g5_q, g5_d;
  logic               pwr_ok_q, pwr_ok_d;
  logic [MAG_W-1:0]   peak_h_q, peak_h_d, peak_v_q, peak_v_d;
  logic [33:0]        mul_q;
  logic [PULSE_W-1:0] psh_q [NUM_THR];
  logic [PULSE_W-1:0] psh_d [NUM_THR];
  logic [7:0]         led_sh_q, led_sh_d;
  logic [9:0]         lvl_sum_q, lvl_sum_d;
  logic [4:0]         stall_q, stall_d;
  logic               out_valid_q, out_valid_d;
  logic [PULSE_W-1:0] pout_q [NUM_THR];
  logic [PULSE_W-1:0] pout_d [NUM_THR];
  logic [7:0]         led_out_q, led_out_d;
  logic               esc_out_q, esc_out_d;

  // datapath signals
  logic [MAG_W-1:0]   t0, mag0, peak, lim, res, t_new;
  logic               horiz, corr_cond, t_rot, act_rot;
  logic [33:0]        den_c;
  logic [16:0]        mul_a, mul_b;
  logic [ACT_W-1:0]   act0, act_new, act_mag;
  logic signed [17:0] dlt;
  logic [8:0]         qn;
  logic [9:0]         qc;
  logic [10:0]        floor_v;
  logic [13:0]        psum;
  logic [PULSE_W-1:0] pulse;
  logic               led_bit, stall_hit;
  logic [4:0]         stall_n;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  tcs_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // element at the head of the rotating line
  always_comb begin
    t0    = t_q[0];
    mag0  = t0[MAG_W-1] ? (17'd0 - t0) : t0;
    horiz = ~k_q[2];
    corr_cond = horiz ? ($signed(t0) < -17'sd640) : ($signed(t0) > 17'sd640);
    den_c = 34'({coef_b_q, 6'd0}) + mul_q;
    peak  = horiz ? peak_h_q : peak_v_q;
    lim   = horiz ? 17'd32768 : 17'd32767;
    res   = (div_rsp.quot > 37'(lim)) ? lim : div_rsp.quot[MAG_W-1:0];
    // slew toward target
    act0 = act_q[0];
    dlt  = $signed({t0[MAG_W-1], t0}) - $signed({{4{act0[ACT_W-1]}}, act0});
    if (dlt >= 18'sd320) begin
      act_new = act0 + 14'd320;
    end else if (dlt <= -18'sd320) begin
      act_new = act0 - 14'd320;
    end else begin
      act_new = t0[ACT_W-1:0];
    end
    act_mag = act_new[ACT_W-1] ? (14'd0 - act_new) : act_new;
    // pulse from |g5*act| / 320
    qn      = div_rsp.quot[8:0];
    qc      = {1'b0, qn} + {9'd0, |div_rsp.rem};
    floor_v = act0[ACT_W-1] ? (11'd0 - {1'b0, qc}) : {2'b00, qn};
    psum    = {2'b00, neutral_q} + {{3{floor_v[10]}}, floor_v};
    if (psum[13]) begin
      pulse = '0;
    end else if (psum[12]) begin
      pulse = 12'd4095;
    end else begin
      pulse = psum[11:0];
    end
    led_bit = (pulse > 12'd1520) || ((pulse < 12'd1480) && led_rev_q);
    // stall counter step
    stall_n   = ((lvl_sum_q > 10'd300) && pwr_ok_q) ? (stall_q + 5'd1) : 5'd0;
    stall_hit = (stall_n >= STALL_LIM);
  end

  // shared multiplier operands
  always_comb begin
    case (state_q)
      S_CORR: begin
        mul_a = {1'b0, coef_a_q};
        mul_b = mag0;
      end
      S_OUT: begin
        mul_a = {12'd0, g5_q};
        mul_b = {3'd0, act_mag};
      end
      default: begin
        mul_a = mag0;
        mul_b = 17'd6400;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    t_d       = t_q;
    act_d     = act_q;
    psh_d     = psh_q;
    led_sh_d  = led_sh_q;
    lvl_sum_d = lvl_sum_q;
    g5_d      = g5_q;
    pwr_ok_d  = pwr_ok_q;
    peak_h_d  = peak_h_q;
    peak_v_d  = peak_v_q;
    stall_d   = stall_q;
    pout_d    = pout_q;
    led_out_d = led_out_q;
    esc_out_d = esc_out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    t_rot     = 1'b0;
    act_rot   = 1'b0;
    t_new     = t0;
    div_req.start = 1'b0;
    div_req.num   = {mag0, 20'd0};
    div_req.den   = den_c;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          t_d[0] = {demand_hhf_i[15], demand_hhf_i};
          t_d[1] = {demand_hhb_i[15], demand_hhb_i};
          t_d[2] = {demand_hvb_i[15], demand_hvb_i};
          t_d[3] = {demand_hvf_i[15], demand_hvf_i};
          t_d[4] = {demand_vhf_i[15], demand_vhf_i};
          t_d[5] = {demand_vhb_i[15], demand_vhb_i};
          t_d[6] = {demand_vvb_i[15], demand_vvb_i};
          t_d[7] = {demand_vvf_i[15], demand_vvf_i};
          g5_d      = gain5(throttle_cut_i, supply_power_i > 16'd10000);
          pwr_ok_d  = (supply_power_i < 16'd50) && (supply_power_i != 16'd0);
          peak_h_d  = '0;
          peak_v_d  = '0;
          lvl_sum_d = '0;
          k_d       = '0;
          state_d   = S_CORR;
        end
      end
      S_CORR: begin
        if (corr_cond) begin
          state_d = S_CMUL;
        end else begin
          t_rot = 1'b1;
          k_d   = k_q + 3'd1;
          if (k_q == 3'd7) state_d = S_PEAK;
        end
      end
      S_CMUL: begin
        if (den_c == '0) begin
          // zero characteristic: pass uncorrected
          t_rot = 1'b1;
          k_d   = k_q + 3'd1;
          state_d = (k_q == 3'd7) ? S_PEAK : S_CORR;
        end else begin
          div_req.start = 1'b1;
          state_d = S_CDIV;
        end
      end
      S_CDIV: begin
        if (div_rsp.done) begin
          t_new = horiz ? (17'd0 - res) : res;
          t_rot = 1'b1;
          k_d   = k_q + 3'd1;
          state_d = (k_q == 3'd7) ? S_PEAK : S_CORR;
        end
      end
      S_PEAK: begin
        if (horiz && (mag0 > peak_h_q)) peak_h_d = mag0;
        if (!horiz && (mag0 > peak_v_q)) peak_v_d = mag0;
        t_rot = 1'b1;
        k_d   = k_q + 3'd1;
        if (k_q == 3'd7) state_d = S_SCALE;
      end
      S_SCALE: begin
        if (peak > 17'd6400) begin
          state_d = S_SMUL;
        end else begin
          t_rot = 1'b1;
          k_d   = k_q + 3'd1;
          if (k_q == 3'd7) state_d = S_OUT;
        end
      end
      S_SMUL: begin
        div_req.start = 1'b1;
        div_req.num   = {3'd0, mul_q};
        div_req.den   = {17'd0, peak};
        state_d = S_SDIV;
      end
      S_SDIV: begin
        if (div_rsp.done) begin
          t_new = t0[MAG_W-1] ? (17'd0 - div_rsp.quot[MAG_W-1:0])
                              : div_rsp.quot[MAG_W-1:0];
          t_rot = 1'b1;
          k_d   = k_q + 3'd1;
          state_d = (k_q == 3'd7) ? S_OUT : S_SCALE;
        end
      end
      S_OUT: begin
        act_d[0] = act_new;
        state_d  = S_OMUL;
      end
      S_OMUL: begin
        div_req.start = 1'b1;
        div_req.num   = {3'd0, mul_q};
        div_req.den   = 34'd320;
        state_d = S_ODIV;
      end
      S_ODIV: begin
        if (div_rsp.done) begin
          for (int i = 0; i < NUM_THR - 1; i++) psh_d[i] = psh_q[i+1];
          psh_d[NUM_THR-1] = pulse;
          led_sh_d  = {led_bit, led_sh_q[7:1]};
          lvl_sum_d = lvl_sum_q + {3'd0, qn[8:2]};
          t_rot   = 1'b1;
          act_rot = 1'b1;
          k_d     = k_q + 3'd1;
          state_d = (k_q == 3'd7) ? S_FIN : S_OUT;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          pout_d      = psh_q;
          led_out_d   = led_sh_q;
          esc_out_d   = stall_hit;
          stall_d     = stall_hit ? 5'd0 : stall_n;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // rotate the working line by one element
    if (t_rot) begin
      for (int i = 0; i < NUM_THR - 1; i++) t_d[i] = t_q[i+1];
      t_d[NUM_THR-1] = t_new;
    end
    if (act_rot) begin
      for (int i = 0; i < NUM_THR - 1; i++) act_d[i] = act_q[i+1];
      act_d[NUM_THR-1] = act_q[0];
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q  <= 16'd82;
      coef_b_q  <= 16'd16384;
      neutral_q <= 12'd1500;
      led_rev_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_COEF_A:  coef_a_q  <= cfg_data_i;
        CFG_COEF_B:  coef_b_q  <= cfg_data_i;
        CFG_NEUTRAL: neutral_q <= cfg_data_i[11:0];
        CFG_LED_REV: led_rev_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      stall_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_THR; i++) act_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      stall_q     <= stall_d;
      out_valid_q <= out_valid_d;
      act_q       <= act_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    t_q       <= t_d;
    g5_q      <= g5_d;
    pwr_ok_q  <= pwr_ok_d;
    peak_h_q  <= peak_h_d;
    peak_v_q  <= peak_v_d;
    mul_q     <= mul_a * mul_b;
    psh_q     <= psh_d;
    led_sh_q  <= led_sh_d;
    lvl_sum_q <= lvl_sum_d;
    pout_q    <= pout_d;
    led_out_q <= led_out_d;
    esc_out_q <= esc_out_d;
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign pulse_hhf_o = pout_q[0];
  assign pulse_hhb_o = pout_q[1];
  assign pulse_hvb_o = pout_q[2];
  assign pulse_hvf_o = pout_q[3];
  assign pulse_vhf_o = pout_q[4];
  assign pulse_vhb_o = pout_q[5];
  assign pulse_vvb_o = pout_q[6];
  assign pulse_vvf_o = pout_q[7];
  assign led_mask_o  = led_out_q;
  assign stall_reset_o = esc_out_q;

endmodule

>>> sv/tcs_serial_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tcs_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module tcs_serial_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tcs_pkg::div_req_t req_i,
  output tcs_pkg::div_rsp_t rsp_o
);
  import tcs_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  // one shift-subtract step; dividend bits shift out as quotient bits shift in
  always_comb begin
    trial  = {rem_q, quo_q[NUM_W-1]};
    diff   = trial - {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> sv/tcs_chk.sv
// Port-level checker of the thruster command shaper, bound to the top.
// Depends on thruster_command_shaper_assert.svh.
`timescale 1ns / 1ps
`include "thruster_command_shaper_assert.svh"

module tcs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [11:0] pulse_hhf_o,
  input logic [7:0]  led_mask_o,
  input logic        stall_reset_o
);

  logic        in_xfer;
  logic        out_stall;
  logic [20:0] out_word;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign out_word  = {pulse_hhf_o, led_mask_o, stall_reset_o};

  // no result shown after a reset edge
  `TCS_ASSERT_RST(a_rst_no_valid, (!rst_ni |=> !out_valid_o), "out_valid after reset")

  // a stalled result holds
  `TCS_ASSERT(a_out_hold, (out_stall |=> out_valid_o && $stable(out_word)), "stalled result changed")

  // one item at a time: busy right after a transfer in
  `TCS_ASSERT(a_busy_after_in, (in_xfer |=> !in_ready_o), "ready right after input transfer")

  // a result never appears the cycle after an input transfer
  `TCS_ASSERT(a_no_early_out, (in_xfer |=> !$rose(out_valid_o)), "result too early")

endmodule

bind thruster_command_shaper tcs_chk u_tcs_chk (.*);
